// ----- sv/gtg_pkg.sv -----
package gtg_pkg;

  localparam logic [31:0] LCG_MUL_LO = 32'h00EC_E66D;
  localparam logic [31:0] LCG_MUL_HI = 32'h0000_05DE;
  localparam logic [47:0] LCG_INC    = 48'd11;
  localparam logic [31:0] LN2_Q32    = 32'hB172_17F8;
  localparam logic [31:0] PI_Q30     = 32'hC90F_DAA2;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [20:0] RAD_FULL   = 21'h8_0000;
  localparam logic [63:0] TWO_POW_32 = 64'h1_0000_0000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LCG0,
    S_LCG1,
    S_LCG2,
    S_LCG3,
    S_NORM_INIT,
    S_NORM,
    S_LOG_INIT,
    S_LOG_MUL,
    S_LOG_UPD,
    S_LN_MUL,
    S_SQ_INIT,
    S_SQRT,
    S_RAD,
    S_TRIG_MUL,
    S_ANG,
    S_A2_MUL,
    S_A2,
    S_H_MUL,
    S_H_RCP,
    S_H_CHK,
    S_H_FIX,
    S_SIN_MUL,
    S_SIN,
    S_SCX_MUL,
    S_SCX,
    S_SCY_MUL,
    S_SCY,
    S_DONE
  } gtg_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_LCG_A,
    OP_LCG_B,
    OP_LCG_C,
    OP_NORM_INIT,
    OP_RAD_SAT,
    OP_NORM_STEP,
    OP_LOG_INIT,
    OP_LOG_STEP,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_RAD_LOAD,
    OP_ANG,
    OP_A2,
    OP_H_X,
    OP_H_Q,
    OP_H_FIX,
    OP_SIN,
    OP_SC_C,
    OP_SC_S,
    OP_OUT_LOAD
  } gtg_op_e;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_SL_ML,
    MUL_SL_MH,
    MUL_SH_ML,
    MUL_M_M,
    MUL_T_LN2,
    MUL_R_PI,
    MUL_A_A,
    MUL_A2_V,
    MUL_X_RCP,
    MUL_Q_DEN,
    MUL_A_V,
    MUL_RAD_C,
    MUL_RAD_S
  } gtg_mul_e;

  typedef struct packed {
    gtg_mul_e   mul_sel;
    gtg_op_e    op;
    logic [4:0] cnt;
    logic       pair;
  } gtg_cmd_t;

  typedef struct packed {
    logic rad_zero;
    logic out_free;
  } gtg_stat_t;

  // Taylor denominators: sine steps first, then cosine steps.
  function automatic logic [7:0] h_den(input logic [3:0] idx);
    case (idx)
      4'd0:    h_den = 8'd110;
      4'd1:    h_den = 8'd72;
      4'd2:    h_den = 8'd42;
      4'd3:    h_den = 8'd20;
      4'd4:    h_den = 8'd6;
      4'd5:    h_den = 8'd132;
      4'd6:    h_den = 8'd90;
      4'd7:    h_den = 8'd56;
      4'd8:    h_den = 8'd30;
      4'd9:    h_den = 8'd12;
      4'd10:   h_den = 8'd2;
      default: h_den = 8'd1;
    endcase
  endfunction

  function automatic logic [31:0] h_rcp(input logic [3:0] idx);
    case (idx)
      4'd0:    h_rcp = 32'(TWO_POW_32 / 64'd110);
      4'd1:    h_rcp = 32'(TWO_POW_32 / 64'd72);
      4'd2:    h_rcp = 32'(TWO_POW_32 / 64'd42);
      4'd3:    h_rcp = 32'(TWO_POW_32 / 64'd20);
      4'd4:    h_rcp = 32'(TWO_POW_32 / 64'd6);
      4'd5:    h_rcp = 32'(TWO_POW_32 / 64'd132);
      4'd6:    h_rcp = 32'(TWO_POW_32 / 64'd90);
      4'd7:    h_rcp = 32'(TWO_POW_32 / 64'd56);
      4'd8:    h_rcp = 32'(TWO_POW_32 / 64'd30);
      4'd9:    h_rcp = 32'(TWO_POW_32 / 64'd12);
      4'd10:   h_rcp = 32'(TWO_POW_32 / 64'd2);
      default: h_rcp = 32'hFFFF_FFFF;
    endcase
  endfunction

endpackage

// ----- sv/gtg_ctrl.sv -----
module gtg_ctrl import gtg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  gtg_stat_t stat_i,
  output gtg_cmd_t  cmd_o
);

  gtg_state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       pair_q, pair_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 5'd0;
      pair_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pair_q  <= pair_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pair_d  = pair_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LCG0;
          cnt_d   = 5'd0;
          pair_d  = 1'b0;
        end
      end
      S_LCG0: state_d = S_LCG1;
      S_LCG1: state_d = S_LCG2;
      S_LCG2: state_d = S_LCG3;
      S_LCG3: begin
        if (cnt_q == 5'd3) begin
          cnt_d   = 5'd0;
          state_d = S_NORM_INIT;
        end else begin
          cnt_d   = cnt_q + 5'd1;
          state_d = S_LCG0;
        end
      end
      S_NORM_INIT: begin
        cnt_d   = 5'd0;
        state_d = stat_i.rad_zero ? S_TRIG_MUL : S_NORM;
      end
      S_NORM: begin
        if (cnt_q == 5'd5) begin
          cnt_d   = 5'd0;
          state_d = S_LOG_INIT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_LOG_INIT: state_d = S_LOG_MUL;
      S_LOG_MUL:  state_d = S_LOG_UPD;
      S_LOG_UPD: begin
        if (cnt_q == 5'd23) begin
          cnt_d   = 5'd0;
          state_d = S_LN_MUL;
        end else begin
          cnt_d   = cnt_q + 5'd1;
          state_d = S_LOG_MUL;
        end
      end
      S_LN_MUL:  state_d = S_SQ_INIT;
      S_SQ_INIT: begin
        cnt_d   = 5'd0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (cnt_q == 5'd20) begin
          cnt_d   = 5'd0;
          state_d = S_RAD;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_RAD:      state_d = S_TRIG_MUL;
      S_TRIG_MUL: state_d = S_ANG;
      S_ANG:      state_d = S_A2_MUL;
      S_A2_MUL:   state_d = S_A2;
      S_A2: begin
        cnt_d   = 5'd0;
        state_d = S_H_MUL;
      end
      S_H_MUL: state_d = S_H_RCP;
      S_H_RCP: state_d = S_H_CHK;
      S_H_CHK: state_d = S_H_FIX;
      S_H_FIX: begin
        if (cnt_q == 5'd4) begin
          cnt_d   = cnt_q + 5'd1;
          state_d = S_SIN_MUL;
        end else if (cnt_q == 5'd10) begin
          cnt_d   = 5'd0;
          state_d = S_SCX_MUL;
        end else begin
          cnt_d   = cnt_q + 5'd1;
          state_d = S_H_MUL;
        end
      end
      S_SIN_MUL: state_d = S_SIN;
      S_SIN:     state_d = S_H_MUL;
      S_SCX_MUL: state_d = S_SCX;
      S_SCX:     state_d = pair_q ? S_DONE : S_SCY_MUL;
      S_SCY_MUL: state_d = S_SCY;
      S_SCY: begin
        pair_d  = 1'b1;
        state_d = S_NORM_INIT;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.op      = OP_NONE;
    cmd_o.cnt     = cnt_q;
    cmd_o.pair    = pair_q;
    in_stall_o    = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_START;
        end
      end
      S_LCG0: cmd_o.mul_sel = MUL_SL_ML;
      S_LCG1: begin
        cmd_o.mul_sel = MUL_SL_MH;
        cmd_o.op      = OP_LCG_A;
      end
      S_LCG2: begin
        cmd_o.mul_sel = MUL_SH_ML;
        cmd_o.op      = OP_LCG_B;
      end
      S_LCG3:      cmd_o.op = OP_LCG_C;
      S_NORM_INIT: cmd_o.op = stat_i.rad_zero ? OP_RAD_SAT : OP_NORM_INIT;
      S_NORM:      cmd_o.op = OP_NORM_STEP;
      S_LOG_INIT:  cmd_o.op = OP_LOG_INIT;
      S_LOG_MUL:   cmd_o.mul_sel = MUL_M_M;
      S_LOG_UPD:   cmd_o.op = OP_LOG_STEP;
      S_LN_MUL:    cmd_o.mul_sel = MUL_T_LN2;
      S_SQ_INIT:   cmd_o.op = OP_SQ_INIT;
      S_SQRT:      cmd_o.op = OP_SQ_STEP;
      S_RAD:       cmd_o.op = OP_RAD_LOAD;
      S_TRIG_MUL:  cmd_o.mul_sel = MUL_R_PI;
      S_ANG:       cmd_o.op = OP_ANG;
      S_A2_MUL:    cmd_o.mul_sel = MUL_A_A;
      S_A2:        cmd_o.op = OP_A2;
      S_H_MUL:     cmd_o.mul_sel = MUL_A2_V;
      S_H_RCP: begin
        cmd_o.mul_sel = MUL_X_RCP;
        cmd_o.op      = OP_H_X;
      end
      S_H_CHK: begin
        cmd_o.mul_sel = MUL_Q_DEN;
        cmd_o.op      = OP_H_Q;
      end
      S_H_FIX:   cmd_o.op = OP_H_FIX;
      S_SIN_MUL: cmd_o.mul_sel = MUL_A_V;
      S_SIN:     cmd_o.op = OP_SIN;
      S_SCX_MUL: cmd_o.mul_sel = MUL_RAD_C;
      S_SCX:     cmd_o.op = OP_SC_C;
      S_SCY_MUL: cmd_o.mul_sel = MUL_RAD_S;
      S_SCY:     cmd_o.op = OP_SC_S;
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_OUT_LOAD;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ----- sv/gtg_dp.sv -----
module gtg_dp import gtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic        [47:0] seed_value_i,
  input  logic               restart_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic signed [15:0] gauss_x_o,
  output logic signed [15:0] gauss_y_o,
  output logic signed [15:0] gauss_z_o,
  input  gtg_cmd_t           cmd_i,
  output gtg_stat_t          stat_o
);

  logic [47:0] seed_q, lcg_q, acc_q;
  logic [47:0] u1_q, u3_q;
  logic [31:0] u2_q, u4_q;
  logic [63:0] p_q;
  logic [31:0] mul_a, mul_b;
  logic [47:0] nrm_q, nrm_d;
  logic [5:0]  shc_q, shc_d;
  logic [31:0] m_q;
  logic [23:0] frac_q;
  logic [29:0] t_val;
  logic [41:0] sqn_q, res_q, bitv;
  logic [42:0] trial;
  logic [20:0] rad_q;
  logic [31:0] phase;
  logic [2:0]  oct;
  logic [29:0] ang_r;
  logic [29:0] a_q, a2_q, x_q, q_q, rem, qf;
  logic [30:0] v_q, sin_q, sb, cb, smag, cmag;
  logic        sneg, cneg;
  logic [15:0] res_x_q, res_y_q, res_z_q;
  logic [15:0] out_x_q, out_y_q, out_z_q;
  logic        out_valid_q;
  logic [47:0] lcg_nx;
  logic [63:0] vsum, asum;
  logic [32:0] sq;
  logic [7:0]  den;

  function automatic logic [15:0] scale_q12(input logic [63:0] prod, input logic neg);
    logic [63:0] s;
    logic [29:0] mag;
    logic [29:0] lim;
    s   = prod + 64'h2_0000_0000;
    mag = s[63:34];
    lim = neg ? 30'd32768 : 30'd32767;
    if (mag > lim) begin
      mag = lim;
    end
    scale_q12 = neg ? 16'(17'h1_0000 - mag[16:0]) : mag[15:0];
  endfunction

  assign den    = h_den(cmd_i.cnt[3:0]);
  assign t_val  = {6'(shc_q + 6'd1), 24'd0} - {6'd0, frac_q};
  assign phase  = cmd_i.pair ? u4_q : u2_q;
  assign oct    = phase[31:29];
  assign ang_r  = oct[0] ? (30'h2000_0000 - {1'b0, phase[28:0]}) : {1'b0, phase[28:0]};
  assign lcg_nx = acc_q + {p_q[23:0], 24'd0} + LCG_INC;
  assign vsum   = {p_q[62:0], 1'b0} + 64'h80_0000;
  assign asum   = p_q + 64'h4000_0000;
  assign sq     = p_q[63:31];
  assign bitv   = 42'd1 << (6'd40 - {cmd_i.cnt, 1'b0});
  assign trial  = {1'b0, res_q} + {1'b0, bitv};
  assign rem    = x_q - p_q[29:0];
  assign qf     = (rem >= 30'(den)) ? (q_q + 30'd1) : q_q;

  assign stat_o.rad_zero = ((cmd_i.pair ? u3_q : u1_q) == 48'd0);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (oct[0]) begin
      sb = v_q;
      cb = sin_q;
    end else begin
      sb = sin_q;
      cb = v_q;
    end
    case (oct[2:1])
      2'd0: begin
        smag = sb; sneg = 1'b0; cmag = cb; cneg = 1'b0;
      end
      2'd1: begin
        smag = cb; sneg = 1'b0; cmag = sb; cneg = 1'b1;
      end
      2'd2: begin
        smag = sb; sneg = 1'b1; cmag = cb; cneg = 1'b1;
      end
      default: begin
        smag = cb; sneg = 1'b1; cmag = sb; cneg = 1'b0;
      end
    endcase
  end

  always_comb begin
    nrm_d = nrm_q;
    shc_d = shc_q;
    case (cmd_i.cnt[2:0])
      3'd0: if (nrm_q[47:16] == 32'd0) begin
        nrm_d = nrm_q << 32; shc_d = shc_q + 6'd32;
      end
      3'd1: if (nrm_q[47:32] == 16'd0) begin
        nrm_d = nrm_q << 16; shc_d = shc_q + 6'd16;
      end
      3'd2: if (nrm_q[47:40] == 8'd0) begin
        nrm_d = nrm_q << 8; shc_d = shc_q + 6'd8;
      end
      3'd3: if (nrm_q[47:44] == 4'd0) begin
        nrm_d = nrm_q << 4; shc_d = shc_q + 6'd4;
      end
      3'd4: if (nrm_q[47:46] == 2'd0) begin
        nrm_d = nrm_q << 2; shc_d = shc_q + 6'd2;
      end
      3'd5: if (!nrm_q[47]) begin
        nrm_d = nrm_q << 1; shc_d = shc_q + 6'd1;
      end
      default: begin
        nrm_d = nrm_q;
      end
    endcase
  end

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (cmd_i.mul_sel)
      MUL_SL_ML: begin mul_a = {8'd0, lcg_q[23:0]};  mul_b = LCG_MUL_LO; end
      MUL_SL_MH: begin mul_a = {8'd0, lcg_q[23:0]};  mul_b = LCG_MUL_HI; end
      MUL_SH_ML: begin mul_a = {8'd0, lcg_q[47:24]}; mul_b = LCG_MUL_LO; end
      MUL_M_M:   begin mul_a = m_q;                  mul_b = m_q; end
      MUL_T_LN2: begin mul_a = {2'd0, t_val};        mul_b = LN2_Q32; end
      MUL_R_PI:  begin mul_a = {2'd0, ang_r};        mul_b = PI_Q30; end
      MUL_A_A:   begin mul_a = {2'd0, a_q};          mul_b = {2'd0, a_q}; end
      MUL_A2_V:  begin mul_a = {2'd0, a2_q};         mul_b = {1'b0, v_q}; end
      MUL_X_RCP: begin mul_a = {2'd0, p_q[59:30]};   mul_b = h_rcp(cmd_i.cnt[3:0]); end
      MUL_Q_DEN: begin mul_a = {2'd0, p_q[61:32]};   mul_b = {24'd0, den}; end
      MUL_A_V:   begin mul_a = {2'd0, a_q};          mul_b = {1'b0, v_q}; end
      MUL_RAD_C: begin mul_a = {11'd0, rad_q};       mul_b = {1'b0, cmag}; end
      MUL_RAD_S: begin mul_a = {11'd0, rad_q};       mul_b = {1'b0, smag}; end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_sel != MUL_NONE) begin
      p_q <= {32'd0, mul_a} * {32'd0, mul_b};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= 48'd0;
      lcg_q       <= 48'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        seed_q <= seed_value_i;
      end
      if (cmd_i.op == OP_START && restart_i) begin
        lcg_q <= seed_q;
      end else if (cmd_i.op == OP_LCG_C) begin
        lcg_q <= lcg_nx;
      end
      if (cmd_i.op == OP_OUT_LOAD) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LCG_A: acc_q <= p_q[47:0];
      OP_LCG_B: acc_q <= acc_q + {p_q[23:0], 24'd0};
      OP_LCG_C: begin
        case (cmd_i.cnt[1:0])
          2'd0:    u1_q <= lcg_nx;
          2'd1:    u2_q <= lcg_nx[47:16];
          2'd2:    u3_q <= lcg_nx;
          default: u4_q <= lcg_nx[47:16];
        endcase
      end
      OP_NORM_INIT: begin
        nrm_q <= cmd_i.pair ? u3_q : u1_q;
        shc_q <= 6'd0;
      end
      OP_RAD_SAT:   rad_q <= RAD_FULL;
      OP_NORM_STEP: begin
        nrm_q <= nrm_d;
        shc_q <= shc_d;
      end
      OP_LOG_INIT: begin
        m_q    <= nrm_q[47:16];
        frac_q <= 24'd0;
      end
      OP_LOG_STEP: begin
        m_q    <= sq[32] ? sq[32:1] : sq[31:0];
        frac_q <= {frac_q[22:0], sq[32]};
      end
      OP_SQ_INIT: begin
        sqn_q <= {2'd0, vsum[63:24]};
        res_q <= 42'd0;
      end
      OP_SQ_STEP: begin
        if ({1'b0, sqn_q} >= trial) begin
          sqn_q <= sqn_q - trial[41:0];
          res_q <= (res_q >> 1) + bitv;
        end else begin
          res_q <= res_q >> 1;
        end
      end
      OP_RAD_LOAD: rad_q <= res_q[20:0];
      OP_ANG:      a_q <= asum[60:31];
      OP_A2: begin
        a2_q <= p_q[59:30];
        v_q  <= ONE_Q30;
      end
      OP_H_X:   x_q <= p_q[59:30];
      OP_H_Q:   q_q <= p_q[61:32];
      OP_H_FIX: v_q <= ONE_Q30 - {1'b0, qf};
      OP_SIN: begin
        sin_q <= p_q[60:30];
        v_q   <= ONE_Q30;
      end
      OP_SC_C: begin
        if (cmd_i.pair) begin
          res_z_q <= scale_q12(p_q, cneg);
        end else begin
          res_x_q <= scale_q12(p_q, cneg);
        end
      end
      OP_SC_S: res_y_q <= scale_q12(p_q, sneg);
      OP_OUT_LOAD: begin
        out_x_q <= res_x_q;
        out_y_q <= res_y_q;
        out_z_q <= res_z_q;
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign gauss_x_o   = out_x_q;
  assign gauss_y_o   = out_y_q;
  assign gauss_z_o   = out_z_q;

endmodule

// ----- sv/gaussian_triple_generator_core.sv -----
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i / in_stall_o  restart_i
// result    out        out_valid_o / out_stall_i gauss_x_o, gauss_y_o, gauss_z_o
// seed      in         cfg_valid_i / cfg_ready_o seed_value_i
//
// A request runs on the single shared 32x32 multiplier through the 24-step log loop,
// the 21-step square root and the 11 Horner steps of the sine and cosine series;
// each zero uniform skips the normalise, log and square-root steps and shortens it.
// Reset clears the generator state and the seed to zero and empties the output.
// The next request is taken while a result still waits in the output register;
// a stalled output holds the block in its final state until the transaction ends.
module gaussian_triple_generator_core import gtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [47:0] seed_value_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] gauss_x_o,
  output logic signed [15:0] gauss_y_o,
  output logic signed [15:0] gauss_z_o
);

  gtg_cmd_t  cmd;
  gtg_stat_t stat;

  assign cfg_ready_o = 1'b1;

  gtg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gtg_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .seed_value_i (seed_value_i),
    .restart_i    (restart_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .gauss_x_o    (gauss_x_o),
    .gauss_y_o    (gauss_y_o),
    .gauss_z_o    (gauss_z_o),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block did not go busy after an accepted transaction");

  a_result_at_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result appeared while the block was still busy");

endmodule
